// ===== hw/rtl/ses_pkg.sv =====
package ses_pkg;

  localparam int unsigned IndexBitsDef  = 16;
  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned ClassW   = 2;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned HopW     = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ClassW-1:0] ClsCry   = 2'd0;
  localparam logic [ClassW-1:0] ClsShout = 2'd1;

  localparam logic KindCry   = 1'b0;
  localparam logic KindShout = 1'b1;

  localparam logic [ThrW-1:0] StartFramesRst = 8'd3;
  localparam logic [ThrW-1:0] EndFramesRst   = 8'd3;
  localparam logic [HopW-1:0] HopLengthRst   = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegStartFrames = 2'd0,
    RegEndFrames   = 2'd1,
    RegHopLength   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } ses_q_stat_t;

endpackage

// ===== hw/rtl/ses_if.sv =====
interface ses_in_if import ses_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ClassW-1:0] frame_class;
  logic              stream_end;

  modport source (output valid, frame_class, stream_end, input ready);
  modport sink   (input valid, frame_class, stream_end, output ready);
endinterface

interface ses_out_if import ses_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             event_kind;
  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] end_time;
  logic             end_known;
  logic             last_result;

  modport source (output valid, event_kind, start_time, end_time, end_known, last_result,
                  input ready);
  modport sink   (input valid, event_kind, start_time, end_time, end_known, last_result,
                  output ready);
endinterface

// ===== hw/rtl/ses_queue.sv =====
module ses_queue import ses_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [Width-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [Width-1:0]  rdata_o,
  output ses_q_stat_t       stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/ses_front.sv =====
module ses_front import ses_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef,
  parameter int unsigned RecW      = 2 * (2 * IndexBits + 2) + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ses_in_if.sink          frame_i,
  input  logic [ThrW-1:0] start_frames_i,
  input  logic [ThrW-1:0] end_frames_i,
  input  ses_q_stat_t     q_stat_i,
  output logic            push_o,
  output logic [RecW-1:0] rec_o
);

  localparam int unsigned SumW = (IndexBits > CountW) ? IndexBits : CountW;

  typedef struct packed {
    logic                 kind;
    logic [IndexBits-1:0] first_idx;
    logic [IndexBits-1:0] end_idx;
    logic                 known;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  logic [IndexBits-1:0] index_q;
  logic [1:0]           seen_q, active_q;
  logic [IndexBits-1:0] first_q [2];
  logic [IndexBits-1:0] last_q  [2];
  logic [CountW-1:0]    count_q [2];

  logic [1:0]           match, seen1, start, active2, active3, close_hit, fin_act;
  logic [IndexBits-1:0] first1 [2];
  logic [IndexBits-1:0] last1  [2];
  logic [CountW-1:0]    count1 [2];
  logic [IndexBits-1:0] run_end [2];
  logic [IndexBits-1:0] gap [2];
  logic [SumW-1:0]      run_sum [2];
  logic [IndexBits-1:0] next_idx;
  logic                 accept, start_any, any_close, fin_any, close_kind, fin_kind;
  res_t                 res_a, res_b, res_c, res_second;
  rec_t                 rec;

  assign frame_i.ready = !q_stat_i.full;
  assign accept        = frame_i.valid && frame_i.ready;
  assign next_idx      = index_q + 1'b1;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      match[k]   = (frame_i.frame_class == ClassW'(k));
      seen1[k]   = seen_q[k] || match[k];
      first1[k]  = (match[k] && !seen_q[k]) ? index_q : first_q[k];
      last1[k]   = match[k] ? index_q : last_q[k];
      count1[k]  = (match[k] && (count_q[k] != '1)) ? count_q[k] + 1'b1 : count_q[k];
      run_sum[k] = SumW'(first1[k]) + SumW'(count1[k]) - 1'b1;
      run_end[k] = run_sum[k][IndexBits-1:0];
      gap[k]     = index_q - last1[k];
    end
    for (int k = 0; k < 2; k++) begin
      start[k] = seen1[k] && !seen1[1-k] && (index_q == run_end[k]) &&
                 (count1[k] == CountW'(start_frames_i));
    end
    active2 = active_q | start;
    active3 = active2;
    if (active2[0] && active2[1]) begin
      if (first1[0] < first1[1]) begin
        active3[1] = 1'b0;
      end else begin
        active3[0] = 1'b0;
      end
    end
    for (int k = 0; k < 2; k++) begin
      close_hit[k] = active3[k] && seen1[k] && (frame_i.frame_class != ClassW'(k)) &&
                     (gap[k] >= IndexBits'(end_frames_i));
    end
    any_close  = |close_hit;
    close_kind = close_hit[0] ? KindCry : KindShout;
    start_any  = |start;
    for (int k = 0; k < 2; k++) begin
      fin_act[k] = active3[k] && seen1[k] && !any_close && frame_i.stream_end;
    end
    fin_any  = |fin_act;
    fin_kind = fin_act[0] ? KindCry : KindShout;

    res_a.kind      = start[1];
    res_a.first_idx = first1[start[1]];
    res_a.end_idx   = '0;
    res_a.known     = 1'b0;

    res_b.kind      = close_kind;
    res_b.first_idx = first1[close_kind];
    res_b.end_idx   = last1[close_kind] + 1'b1;
    res_b.known     = 1'b1;

    res_c.kind      = fin_kind;
    res_c.first_idx = first1[fin_kind];
    res_c.end_idx   = next_idx;
    res_c.known     = 1'b1;

    res_second = any_close ? res_b : res_c;
    rec.two    = start_any && (any_close || fin_any);
    rec.r0     = start_any ? res_a : res_second;
    rec.r1     = res_second;
  end

  assign push_o = accept && (start_any || any_close || fin_any);
  assign rec_o  = RecW'(rec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q  <= '0;
      seen_q   <= '0;
      active_q <= '0;
      first_q  <= '{default: '0};
      last_q   <= '{default: '0};
      count_q  <= '{default: '0};
    end else if (accept) begin
      index_q <= frame_i.stream_end ? '0 : next_idx;
      if (any_close || frame_i.stream_end) begin
        seen_q   <= '0;
        active_q <= '0;
        first_q  <= '{default: '0};
        last_q   <= '{default: '0};
        count_q  <= '{default: '0};
      end else begin
        seen_q   <= seen1;
        active_q <= active3;
        first_q  <= first1;
        last_q   <= last1;
        count_q  <= count1;
      end
    end
  end

endmodule

// ===== hw/rtl/ses_back.sv =====
module ses_back import ses_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef,
  parameter int unsigned RecW      = 2 * (2 * IndexBits + 2) + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [RecW-1:0] rec_i,
  input  ses_q_stat_t     q_stat_i,
  input  logic [HopW-1:0] hop_length_i,
  output logic            pop_o,
  ses_out_if.source       result_o
);

  localparam int unsigned PW = IndexBits + HopW;

  typedef struct packed {
    logic                 kind;
    logic [IndexBits-1:0] first_idx;
    logic [IndexBits-1:0] end_idx;
    logic                 known;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  rec_t                rec;
  res_t                cur;
  logic                sel_q, sel_d, valid_q, valid_d, load, last;
  logic [PW-1:0]       prod_start, prod_end;
  logic [PW+TimeW-1:0] ext_start, ext_end;
  logic                kind_q, known_q, last_q;
  logic [TimeW-1:0]    start_q, end_q;

  assign rec  = rec_t'(rec_i);
  assign cur  = sel_q ? rec.r1 : rec.r0;
  assign last = sel_q || !rec.two;
  assign load = !q_stat_i.empty && (!valid_q || result_o.ready);
  assign pop_o = load && last;

  assign prod_start = PW'(cur.first_idx) * PW'(hop_length_i);
  assign prod_end   = PW'(cur.end_idx) * PW'(hop_length_i);
  assign ext_start  = (PW + TimeW)'(prod_start);
  assign ext_end    = (PW + TimeW)'(prod_end);

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    if (load) begin
      sel_d   = !last;
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= cur.kind;
      start_q <= ext_start[TimeW-1:0];
      end_q   <= ext_end[TimeW-1:0];
      known_q <= cur.known;
      last_q  <= last;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.event_kind  = kind_q;
  assign result_o.start_time  = start_q;
  assign result_o.end_time    = end_q;
  assign result_o.end_known   = known_q;
  assign result_o.last_result = last_q;

endmodule

// ===== hw/rtl/sound_event_segmenter.sv =====
// Sound event segmenter.
// frame_i: one beat per classified frame (frame_class 0 cry, 1 shout, 2/3 other;
//   stream_end closes any open event after this frame and zeroes the frame index).
// result_o: zero, one or two beats per frame; last_result marks the final beat
//   caused by a frame. end_known 0 is a start notice (end_time 0), 1 a closed event.
// Times are frame index times hop_length, modulo 2^32.
// Config: cfg_we_i with cfg_idx_i 0 start_frames, 1 end_frames, 2 hop_length;
//   write only while no frame is in flight.
// Throughput: one frame per cycle while the queue is not full; a frame with two
//   results gives two output beats. The front tracks event state for each accepted frame; the back
//   scales times with two IndexBits x 16 multiplies per result.
// A result beat passes through a queue entry, then the output register, before
//   the receiver can take it.
// A stalled receiver holds the output beat; the queue fills, then frame_i.ready
//   drops. Reset clears all event state, the index, the queue and the config
//   registers to start_frames 3, end_frames 3, hop_length 1.
module sound_event_segmenter import ses_pkg::*; #(
  parameter int unsigned IndexBits  = IndexBitsDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ses_in_if.sink              frame_i,
  ses_out_if.source           result_o
);

  localparam int unsigned RecW = 2 * (2 * IndexBits + 2) + 1;

  logic [ThrW-1:0] start_frames_q, end_frames_q;
  logic [HopW-1:0] hop_length_q;
  logic            push, pop;
  logic [RecW-1:0] rec_wr, rec_rd;
  ses_q_stat_t     q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_frames_q <= StartFramesRst;
      end_frames_q   <= EndFramesRst;
      hop_length_q   <= HopLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartFrames: start_frames_q <= cfg_wdata_i[ThrW-1:0];
        RegEndFrames:   end_frames_q   <= cfg_wdata_i[ThrW-1:0];
        RegHopLength:   hop_length_q   <= cfg_wdata_i[HopW-1:0];
        default: ;
      endcase
    end
  end

  ses_front #(
    .IndexBits (IndexBits),
    .RecW      (RecW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (frame_i),
    .start_frames_i (start_frames_q),
    .end_frames_i   (end_frames_q),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .rec_o          (rec_wr)
  );

  ses_queue #(
    .Width (RecW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_wr),
    .pop_i   (pop),
    .rdata_o (rec_rd),
    .stat_o  (q_stat)
  );

  ses_back #(
    .IndexBits (IndexBits),
    .RecW      (RecW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (rec_rd),
    .q_stat_i     (q_stat),
    .hop_length_i (hop_length_q),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

// ===== hw/rtl/ses_checker.sv =====
module ses_checker import ses_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [TimeW-1:0] out_end_time_i,
  input logic             out_end_known_i
);

  // output beat held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // start notices carry no end time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_end_known_i |-> out_end_time_i == '0)
    else $error("start notice with non-zero end time");

endmodule

bind sound_event_segmenter ses_checker u_ses_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_end_time_i  (result_o.end_time),
  .out_end_known_i (result_o.end_known)
);
